@@ rtl/rpba_pkg.sv @@
// Shared types, codes and constants for the RGB pixel blend and add/subtract engine.
`default_nettype none

package rpba_pkg;

	// Channel and weight constants
	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned GRADE_W     = 9;
	localparam int unsigned PERCENT_W   = 7;
	localparam int unsigned APB_DATA_W  = 32;
	localparam int unsigned APB_ADDR_W  = 5;
	localparam int unsigned REG_IDX_W   = 3;

	localparam logic [GRADE_W-1:0] FULL_WEIGHT = 9'd256;
	localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'd255;
	localparam logic [PERCENT_W-1:0] PERCENT_RESET = 7'd100;

	// percent*256/100 = percent*64/25, taken as (percent*5243) >> 11, exact for 7-bit input.
	localparam int unsigned        GRADE_PROD_W = 20;
	localparam logic [12:0]        GRADE_RECIP  = 13'd5243;
	localparam int unsigned        GRADE_SHIFT  = 11;

	typedef enum logic [1:0] {
		OP_BLEND = 2'd0,
		OP_SUB   = 2'd1,
		OP_ADD   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Register indexes on the configuration port (byte address / 4)
	localparam logic [REG_IDX_W-1:0] REG_OPERATION     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRADE_PERCENT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CONST_RED     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CONST_GREEN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CONST_BLUE    = 3'd4;

	typedef struct packed {
		op_t                op;
		logic [GRADE_W-1:0] grade;
		logic [CHAN_W-1:0]  const_red;
		logic [CHAN_W-1:0]  const_green;
		logic [CHAN_W-1:0]  const_blue;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/rgb_pixel_blend_add_sub.sv @@
// Top level of the RGB888 pixel blend and saturating add/subtract engine.
//
// Usage: raise start with a destination and a source pixel on dst_* and src_*;
// the pixel is taken at that clock edge. busy stays low, so a new pixel may be
// offered in every cycle. The pixel passes through the input register and
// then the result register, which drives out_* and a one-cycle done strobe.
// Throughput is one pixel per clock; each channel's two multiplies and their
// sum lie between those two registers. The receiver cannot stall, so each
// result must be taken in the cycle in which done is high.
// The operation, blend percentage and per-channel constants are set over the
// APB port (byte addresses 0, 4, 8, 12, 16). The user must change them only
// while no transaction is in flight; the block itself does not enforce this.
// The blend weight is derived from the percentage when it is written.
// Reset clears the pipeline valid flags, selects blend mode at a weight of
// 100 percent and zeroes the constants.
`default_nettype none

module rgb_pixel_blend_add_sub (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [rpba_pkg::CHAN_W-1:0]         dst_red,
	input  wire logic [rpba_pkg::CHAN_W-1:0]         dst_green,
	input  wire logic [rpba_pkg::CHAN_W-1:0]         dst_blue,
	input  wire logic [rpba_pkg::CHAN_W-1:0]         src_red,
	input  wire logic [rpba_pkg::CHAN_W-1:0]         src_green,
	input  wire logic [rpba_pkg::CHAN_W-1:0]         src_blue,
	output logic                                     done,
	output logic      [rpba_pkg::CHAN_W-1:0]         out_red,
	output logic      [rpba_pkg::CHAN_W-1:0]         out_green,
	output logic      [rpba_pkg::CHAN_W-1:0]         out_blue,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [rpba_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [rpba_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [rpba_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                     pready
);

	rpba_pkg::cfg_t                  cfg;

	logic                            valid_s1;
	logic [rpba_pkg::CHAN_W-1:0]     dst_red_s1;
	logic [rpba_pkg::CHAN_W-1:0]     dst_green_s1;
	logic [rpba_pkg::CHAN_W-1:0]     dst_blue_s1;
	logic [rpba_pkg::CHAN_W-1:0]     src_red_s1;
	logic [rpba_pkg::CHAN_W-1:0]     src_green_s1;
	logic [rpba_pkg::CHAN_W-1:0]     src_blue_s1;

	logic                            valid_s2;
	logic [rpba_pkg::CHAN_W-1:0]     out_red_s2;
	logic [rpba_pkg::CHAN_W-1:0]     out_green_s2;
	logic [rpba_pkg::CHAN_W-1:0]     out_blue_s2;

	logic                            accept;
	logic                            opaque;
	logic [rpba_pkg::CHAN_W-1:0]     red_new;
	logic [rpba_pkg::CHAN_W-1:0]     green_new;
	logic [rpba_pkg::CHAN_W-1:0]     blue_new;

	rpba_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dst_red_s1   <= dst_red;
			dst_green_s1 <= dst_green;
			dst_blue_s1  <= dst_blue;
			src_red_s1   <= src_red;
			src_green_s1 <= src_green;
			src_blue_s1  <= src_blue;
		end
	end

	// An all-black source pixel is transparent in blend mode.
	assign opaque = |{src_red_s1, src_green_s1, src_blue_s1};

	rpba_chan u_chan_red (
		.op     (cfg.op),
		.grade  (cfg.grade),
		.amount (cfg.const_red),
		.dst    (dst_red_s1),
		.src    (src_red_s1),
		.opaque (opaque),
		.result (red_new)
	);

	rpba_chan u_chan_green (
		.op     (cfg.op),
		.grade  (cfg.grade),
		.amount (cfg.const_green),
		.dst    (dst_green_s1),
		.src    (src_green_s1),
		.opaque (opaque),
		.result (green_new)
	);

	rpba_chan u_chan_blue (
		.op     (cfg.op),
		.grade  (cfg.grade),
		.amount (cfg.const_blue),
		.dst    (dst_blue_s1),
		.src    (src_blue_s1),
		.opaque (opaque),
		.result (blue_new)
	);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_red_s2   <= red_new;
			out_green_s2 <= green_new;
			out_blue_s2  <= blue_new;
		end
	end

	assign done      = valid_s2;
	assign out_red   = out_red_s2;
	assign out_green = out_green_s2;
	assign out_blue  = out_blue_s2;

endmodule

`default_nettype wire

@@ rtl/rpba_cfg.sv @@
// Configuration register bank with APB access and precomputed blend weight.
`default_nettype none

module rpba_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [rpba_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [rpba_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [rpba_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                     pready,
	output rpba_pkg::cfg_t                           cfg
);

	rpba_pkg::op_t                           op_q;
	logic [rpba_pkg::PERCENT_W-1:0]          percent_q;
	logic [rpba_pkg::GRADE_W-1:0]            grade_q;
	logic [rpba_pkg::CHAN_W-1:0]             const_red_q;
	logic [rpba_pkg::CHAN_W-1:0]             const_green_q;
	logic [rpba_pkg::CHAN_W-1:0]             const_blue_q;

	logic [rpba_pkg::REG_IDX_W-1:0]          reg_idx;
	logic                                    wr_en;
	logic [rpba_pkg::GRADE_PROD_W-1:0]       grade_prod;
	logic [rpba_pkg::GRADE_W-1:0]            grade_raw;
	logic [rpba_pkg::GRADE_W-1:0]            grade_new;

	assign pready  = 1'b1;
	assign reg_idx = paddr[rpba_pkg::APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// The blend weight is worked out once when the percentage is written.
	always_comb begin
		grade_prod = rpba_pkg::GRADE_PROD_W'(pwdata[rpba_pkg::PERCENT_W-1:0])
			* rpba_pkg::GRADE_PROD_W'(rpba_pkg::GRADE_RECIP);
		grade_raw  = grade_prod[rpba_pkg::GRADE_SHIFT +: rpba_pkg::GRADE_W];
		grade_new  = (grade_raw > rpba_pkg::FULL_WEIGHT) ? rpba_pkg::FULL_WEIGHT : grade_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q          <= rpba_pkg::OP_BLEND;
			percent_q     <= rpba_pkg::PERCENT_RESET;
			grade_q       <= rpba_pkg::FULL_WEIGHT;
			const_red_q   <= '0;
			const_green_q <= '0;
			const_blue_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				rpba_pkg::REG_OPERATION: begin
					op_q <= rpba_pkg::op_t'(pwdata[1:0]);
				end
				rpba_pkg::REG_GRADE_PERCENT: begin
					percent_q <= pwdata[rpba_pkg::PERCENT_W-1:0];
					grade_q   <= grade_new;
				end
				rpba_pkg::REG_CONST_RED: begin
					const_red_q <= pwdata[rpba_pkg::CHAN_W-1:0];
				end
				rpba_pkg::REG_CONST_GREEN: begin
					const_green_q <= pwdata[rpba_pkg::CHAN_W-1:0];
				end
				rpba_pkg::REG_CONST_BLUE: begin
					const_blue_q <= pwdata[rpba_pkg::CHAN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rpba_pkg::REG_OPERATION:     prdata = rpba_pkg::APB_DATA_W'(op_q);
			rpba_pkg::REG_GRADE_PERCENT: prdata = rpba_pkg::APB_DATA_W'(percent_q);
			rpba_pkg::REG_CONST_RED:     prdata = rpba_pkg::APB_DATA_W'(const_red_q);
			rpba_pkg::REG_CONST_GREEN:   prdata = rpba_pkg::APB_DATA_W'(const_green_q);
			rpba_pkg::REG_CONST_BLUE:    prdata = rpba_pkg::APB_DATA_W'(const_blue_q);
			default:                     prdata = '0;
		endcase
	end

	always_comb begin
		cfg.op          = op_q;
		cfg.grade       = grade_q;
		cfg.const_red   = const_red_q;
		cfg.const_green = const_green_q;
		cfg.const_blue  = const_blue_q;
	end

endmodule

`default_nettype wire

@@ rtl/rpba_chan.sv @@
// Datapath for one colour channel: blend, saturating subtract or saturating add.
`default_nettype none

module rpba_chan (
	input  wire rpba_pkg::op_t                   op,
	input  wire logic [rpba_pkg::GRADE_W-1:0]    grade,
	input  wire logic [rpba_pkg::CHAN_W-1:0]     amount,
	input  wire logic [rpba_pkg::CHAN_W-1:0]     dst,
	input  wire logic [rpba_pkg::CHAN_W-1:0]     src,
	input  wire logic                            opaque,
	output logic      [rpba_pkg::CHAN_W-1:0]     result
);

	localparam int unsigned PROD_W = rpba_pkg::CHAN_W + rpba_pkg::GRADE_W;

	logic [rpba_pkg::GRADE_W-1:0]  inv_grade;
	logic [PROD_W-1:0]             dst_prod;
	logic [PROD_W-1:0]             src_prod;
	logic [rpba_pkg::CHAN_W+1:0]   mix_sum;
	logic [rpba_pkg::CHAN_W-1:0]   mix_sat;
	logic [rpba_pkg::CHAN_W-1:0]   sub_sat;
	logic [rpba_pkg::CHAN_W:0]     add_sum;
	logic [rpba_pkg::CHAN_W-1:0]   add_sat;

	always_comb begin
		inv_grade = rpba_pkg::FULL_WEIGHT - grade;
		dst_prod  = PROD_W'(dst) * PROD_W'(inv_grade);
		src_prod  = PROD_W'(src) * PROD_W'(grade);
		mix_sum   = (rpba_pkg::CHAN_W+2)'(dst_prod[PROD_W-1:rpba_pkg::CHAN_W])
			+ (rpba_pkg::CHAN_W+2)'(src_prod[PROD_W-1:rpba_pkg::CHAN_W]);
		mix_sat   = (mix_sum > (rpba_pkg::CHAN_W+2)'(rpba_pkg::CHAN_MAX))
			? rpba_pkg::CHAN_MAX : mix_sum[rpba_pkg::CHAN_W-1:0];

		sub_sat   = (dst > amount) ? (dst - amount) : '0;

		add_sum   = (rpba_pkg::CHAN_W+1)'(dst) + (rpba_pkg::CHAN_W+1)'(amount);
		add_sat   = add_sum[rpba_pkg::CHAN_W] ? rpba_pkg::CHAN_MAX
			: add_sum[rpba_pkg::CHAN_W-1:0];

		unique case (op)
			rpba_pkg::OP_BLEND: result = opaque ? mix_sat : dst;
			rpba_pkg::OP_SUB:   result = sub_sat;
			rpba_pkg::OP_ADD:   result = add_sat;
			rpba_pkg::OP_NONE:  result = dst;
			default:            result = dst;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/rpba_chk.sv @@
// Port-level checker for the pixel engine, bound to the top level.
`default_nettype none

module rpba_chk (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                start,
	input wire logic                                busy,
	input wire logic                                done,
	input wire logic                                pready
);

	// Every transaction taken raises done once it has passed the input and result registers.
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted pixel did not produce a result two cycles later");

	// No result without a matching transaction taken earlier.
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without a matching accepted pixel");

	// The engine takes a pixel in every cycle.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("engine refused a pixel");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("configuration port inserted a wait state");

endmodule

bind rgb_pixel_blend_add_sub rpba_chk u_rpba_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.pready (pready)
);

`default_nettype wire

@@ sim/rgb_pixel_blend_add_sub_tb.sv @@
// Self-checking testbench for the RGB888 pixel blend and saturating add/subtract engine.
module rgb_pixel_blend_add_sub_tb;

	localparam int unsigned RANDOM_PIXELS = 850;
	localparam int unsigned PIPE_DEPTH    = 2;
	localparam int unsigned QUIET_LIMIT   = 300;
	localparam int unsigned REPORT_LIMIT  = 10;

	// Addresses beyond the last register; writes there must change nothing.
	localparam logic [rpba_pkg::REG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [rpba_pkg::REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [rpba_pkg::CHAN_W-1:0] red;
		logic [rpba_pkg::CHAN_W-1:0] green;
		logic [rpba_pkg::CHAN_W-1:0] blue;
	} rgb_t;

	class blend_checker;
		rpba_pkg::op_t                  op_mode;
		logic [rpba_pkg::PERCENT_W-1:0] percent;
		rgb_t                           offset;
		rgb_t                           expected_q[$];
		int unsigned                    failures;

		function new();
			op_mode  = rpba_pkg::OP_BLEND;
			percent  = rpba_pkg::PERCENT_RESET;
			offset   = '0;
			failures = 0;
		endfunction

		function void apply_write(logic [rpba_pkg::APB_ADDR_W-1:0] addr,
				logic [rpba_pkg::APB_DATA_W-1:0] data);
			case (addr[rpba_pkg::APB_ADDR_W-1:2])
				rpba_pkg::REG_OPERATION:     op_mode = rpba_pkg::op_t'(data[1:0]);
				rpba_pkg::REG_GRADE_PERCENT: percent = data[rpba_pkg::PERCENT_W-1:0];
				rpba_pkg::REG_CONST_RED:     offset.red = data[rpba_pkg::CHAN_W-1:0];
				rpba_pkg::REG_CONST_GREEN:   offset.green = data[rpba_pkg::CHAN_W-1:0];
				rpba_pkg::REG_CONST_BLUE:    offset.blue = data[rpba_pkg::CHAN_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [rpba_pkg::CHAN_W-1:0] mix(logic [rpba_pkg::CHAN_W-1:0] d,
				logic [rpba_pkg::CHAN_W-1:0] s, int unsigned grade);
			int unsigned v;
			v = ((32'(d) * (32'd256 - grade)) >> 8) + ((32'(s) * grade) >> 8);
			return (v > 32'd255) ? rpba_pkg::CHAN_MAX : rpba_pkg::CHAN_W'(v);
		endfunction

		function logic [rpba_pkg::CHAN_W-1:0] sub_sat(logic [rpba_pkg::CHAN_W-1:0] d,
				logic [rpba_pkg::CHAN_W-1:0] k);
			return (d > k) ? d - k : '0;
		endfunction

		function logic [rpba_pkg::CHAN_W-1:0] add_sat(logic [rpba_pkg::CHAN_W-1:0] d,
				logic [rpba_pkg::CHAN_W-1:0] k);
			logic [rpba_pkg::CHAN_W:0] v;
			v = {1'b0, d} + {1'b0, k};
			return v[rpba_pkg::CHAN_W] ? rpba_pkg::CHAN_MAX : v[rpba_pkg::CHAN_W-1:0];
		endfunction

		// Works out the new destination pixel for an accepted transaction.
		function void note_pixel(rgb_t dst, rgb_t src);
			int unsigned grade;
			rgb_t        res;
			res = dst;
			case (op_mode)
				rpba_pkg::OP_BLEND: begin
					grade = 32'(percent);
					grade = grade * 32'd256 / 32'd100;
					if (grade > 32'd256)
						grade = 32'd256;
					// An all-black source is transparent.
					if (src != '0) begin
						res.red   = mix(dst.red, src.red, grade);
						res.green = mix(dst.green, src.green, grade);
						res.blue  = mix(dst.blue, src.blue, grade);
					end
				end
				rpba_pkg::OP_SUB: begin
					res.red   = sub_sat(dst.red, offset.red);
					res.green = sub_sat(dst.green, offset.green);
					res.blue  = sub_sat(dst.blue, offset.blue);
				end
				rpba_pkg::OP_ADD: begin
					res.red   = add_sat(dst.red, offset.red);
					res.green = add_sat(dst.green, offset.green);
					res.blue  = add_sat(dst.blue, offset.blue);
				end
				default: ;
			endcase
			expected_q.push_back(res);
		endfunction

		function void check_pixel(rgb_t got);
			rgb_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: r=%0d g=%0d b=%0d",
						got.red, got.green, got.blue);
				return;
			end
			want = expected_q.pop_front();
			if (got.red !== want.red || got.green !== want.green
					|| got.blue !== want.blue) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
						want.red, want.green, want.blue, got.red, got.green, got.blue);
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic [rpba_pkg::CHAN_W-1:0]         dst_red;
	logic [rpba_pkg::CHAN_W-1:0]         dst_green;
	logic [rpba_pkg::CHAN_W-1:0]         dst_blue;
	logic [rpba_pkg::CHAN_W-1:0]         src_red;
	logic [rpba_pkg::CHAN_W-1:0]         src_green;
	logic [rpba_pkg::CHAN_W-1:0]         src_blue;
	logic                                done;
	logic [rpba_pkg::CHAN_W-1:0]         out_red;
	logic [rpba_pkg::CHAN_W-1:0]         out_green;
	logic [rpba_pkg::CHAN_W-1:0]         out_blue;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [rpba_pkg::APB_ADDR_W-1:0]     paddr;
	logic [rpba_pkg::APB_DATA_W-1:0]     pwdata;
	logic [rpba_pkg::APB_DATA_W-1:0]     prdata;
	logic                                pready;

	blend_checker pixel_check = new();
	int unsigned  quiet_cycles = 0;

	rgb_pixel_blend_add_sub i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.dst_red   (dst_red),
		.dst_green (dst_green),
		.dst_blue  (dst_blue),
		.src_red   (src_red),
		.src_green (src_green),
		.src_blue  (src_blue),
		.done      (done),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Observes every transaction on the three ports and keeps the watchdog.
	always @(posedge clk) begin : monitor
		bit active;
		active = 1'b0;
		if (arst_n) begin
			if (done) begin
				pixel_check.check_pixel({out_red, out_green, out_blue});
				active = 1'b1;
			end
			if (start && !busy) begin
				pixel_check.note_pixel({dst_red, dst_green, dst_blue},
					{src_red, src_green, src_blue});
				active = 1'b1;
			end
			if (psel && penable && pwrite && pready) begin
				pixel_check.apply_write(paddr, pwdata);
				active = 1'b1;
			end
			if (active) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	function automatic logic [rpba_pkg::APB_ADDR_W-1:0] reg_addr(
			logic [rpba_pkg::REG_IDX_W-1:0] idx);
		return {idx, 2'b00};
	endfunction

	function automatic logic [rpba_pkg::CHAN_W-1:0] pick_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return rpba_pkg::CHAN_MAX;
			default: return rpba_pkg::CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic rgb_t random_pixel();
		return {pick_chan(), pick_chan(), pick_chan()};
	endfunction

	// Leaves psel high so that back-to-back writes need no extra idle cycle.
	task automatic write_reg(input logic [rpba_pkg::APB_ADDR_W-1:0] addr,
			input logic [rpba_pkg::APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	task automatic release_bus();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_pixel(input rgb_t dst, input rgb_t src, input bit no_gap);
		int unsigned gap;
		gap = no_gap ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		dst_red   <= dst.red;
		dst_green <= dst.green;
		dst_blue  <= dst.blue;
		src_red   <= src.red;
		src_green <= src.green;
		src_blue  <= src.blue;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Stops the stream and waits until every expected pixel has come back.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pixel_check.expected_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic configure(input rpba_pkg::op_t op,
			input logic [rpba_pkg::PERCENT_W-1:0] pct, input rgb_t k);
		settle();
		write_reg(reg_addr(rpba_pkg::REG_OPERATION), 32'(op));
		write_reg(reg_addr(rpba_pkg::REG_GRADE_PERCENT), 32'(pct));
		write_reg(reg_addr(rpba_pkg::REG_CONST_RED), 32'(k.red));
		write_reg(reg_addr(rpba_pkg::REG_CONST_GREEN), 32'(k.green));
		write_reg(reg_addr(rpba_pkg::REG_CONST_BLUE), 32'(k.blue));
		release_bus();
	endtask

	initial begin
		int unsigned                    sent;
		int unsigned                    phase_len;
		bit                             no_gaps;
		rpba_pkg::op_t                  op;
		logic [rpba_pkg::PERCENT_W-1:0] pct;
		rgb_t                           src;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		dst_red   <= '0;
		dst_green <= '0;
		dst_blue  <= '0;
		src_red   <= '0;
		src_green <= '0;
		src_blue  <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: full blend, so a non-black source replaces the destination.
		send_pixel('{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, 1'b0);
		send_pixel('{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0}, 1'b0);
		send_pixel('{8'd18, 8'd200, 8'd77}, '{8'd1, 8'd0, 8'd0}, 1'b1);
		send_pixel('{8'd255, 8'd0, 8'd255}, '{8'd0, 8'd255, 8'd0}, 1'b1);

		configure(rpba_pkg::OP_BLEND, 7'd0, '{8'd0, 8'd0, 8'd0});
		send_pixel('{8'd200, 8'd100, 8'd50}, '{8'd255, 8'd255, 8'd255}, 1'b0);
		send_pixel('{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, 1'b0);

		configure(rpba_pkg::OP_BLEND, 7'd50, '{8'd0, 8'd0, 8'd0});
		send_pixel('{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}, 1'b0);
		send_pixel('{8'd1, 8'd2, 8'd3}, '{8'd254, 8'd253, 8'd252}, 1'b1);

		// Percentages above one hundred clamp the weight to a full replace.
		configure(rpba_pkg::OP_BLEND, 7'd127, '{8'h12, 8'h34, 8'h56});
		send_pixel('{8'd77, 8'd77, 8'd77}, '{8'd0, 8'd0, 8'd0}, 1'b0);
		send_pixel('{8'd10, 8'd20, 8'd30}, '{8'd200, 8'd100, 8'd50}, 1'b0);

		configure(rpba_pkg::OP_SUB, 7'd50, '{8'd255, 8'd0, 8'd128});
		send_pixel('{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0}, 1'b0);
		send_pixel('{8'd0, 8'd0, 8'd0}, '{8'd9, 8'd9, 8'd9}, 1'b1);
		send_pixel('{8'd128, 8'd7, 8'd129}, '{8'd0, 8'd0, 8'd0}, 1'b0);

		configure(rpba_pkg::OP_ADD, 7'd101, '{8'd255, 8'd1, 8'd0});
		send_pixel('{8'd255, 8'd254, 8'd0}, '{8'd0, 8'd0, 8'd0}, 1'b0);
		send_pixel('{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd255}, 1'b0);

		settle();
		write_reg(reg_addr(REG_UNUSED_LO), $urandom);
		write_reg(reg_addr(REG_UNUSED_HI), $urandom);
		release_bus();
		send_pixel('{8'd3, 8'd254, 8'd128}, '{8'd0, 8'd0, 8'd0}, 1'b0);

		configure(rpba_pkg::OP_NONE, 7'd100, '{8'd255, 8'd255, 8'd255});
		send_pixel('{8'd9, 8'd8, 8'd7}, '{8'd255, 8'd255, 8'd255}, 1'b0);
		send_pixel('{8'd255, 8'd0, 8'd255}, '{8'd0, 8'd0, 8'd0}, 1'b0);

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: op = rpba_pkg::OP_BLEND;
				4, 5:       op = rpba_pkg::OP_SUB;
				6, 7:       op = rpba_pkg::OP_ADD;
				default:    op = rpba_pkg::OP_NONE;
			endcase
			case ($urandom_range(0, 7))
				0: pct = 7'd0;
				1: pct = 7'd100;
				2: pct = 7'd127;
				3: pct = 7'd101;
				default: pct = rpba_pkg::PERCENT_W'($urandom_range(0, 127));
			endcase
			configure(op, pct, random_pixel());
			phase_len = $urandom_range(15, 60);
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (phase_len) begin
				src = ($urandom_range(0, 7) == 0) ? rgb_t'('0) : random_pixel();
				send_pixel(random_pixel(), src, no_gaps);
				sent++;
			end
		end

		settle();
		if (pixel_check.failures == 0 && pixel_check.expected_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ rgb_pixel_blend_add_sub.f @@
rtl/rpba_pkg.sv
rtl/rpba_cfg.sv
rtl/rpba_chan.sv
rtl/rgb_pixel_blend_add_sub.sv
rtl/rpba_chk.sv
sim/rgb_pixel_blend_add_sub_tb.sv
